>>> hdl/sdcd_pkg.sv
// Shared constants, types and tables for the SD/MMC card clock divider selector.
package sdcd_pkg;

	localparam int REQ_W    = 31;
	localparam int WORD_W   = 32;
	localparam int HZ_W     = 32;
	localparam int PDIV_W   = 2;
	localparam int MDIV_W   = 4;

	localparam logic [HZ_W-1:0]  OSC_HZ       = 32'd24_000_000;
	localparam logic [REQ_W-1:0] OSC_LIMIT_HZ = 31'd12_000_000;
	// 24 MHz / 2, the PLL numerator unit once the final halving is folded in
	localparam logic [HZ_W-1:0]  PLL_HALF_HZ  = 32'd12_000_000;

	typedef struct packed {
		logic [2:0] sh;
		logic [2:0] odd;
	} kdiv_t;

	// k = (M+1)*(P+1) split into 2^sh * odd; odd is always 1, 3, 5 or 7
	function automatic kdiv_t split_k(input logic [4:0] k);
		kdiv_t r;
		begin
			case (k)
				5'd1:    r = '{sh: 3'd0, odd: 3'd1};
				5'd2:    r = '{sh: 3'd1, odd: 3'd1};
				5'd3:    r = '{sh: 3'd0, odd: 3'd3};
				5'd4:    r = '{sh: 3'd2, odd: 3'd1};
				5'd5:    r = '{sh: 3'd0, odd: 3'd5};
				5'd6:    r = '{sh: 3'd1, odd: 3'd3};
				5'd7:    r = '{sh: 3'd0, odd: 3'd7};
				5'd8:    r = '{sh: 3'd3, odd: 3'd1};
				5'd10:   r = '{sh: 3'd1, odd: 3'd5};
				5'd12:   r = '{sh: 3'd2, odd: 3'd3};
				5'd14:   r = '{sh: 3'd1, odd: 3'd7};
				5'd16:   r = '{sh: 3'd4, odd: 3'd1};
				default: r = '{sh: 3'd0, odd: 3'd1};
			endcase
			return r;
		end
	endfunction

	// floor(2^32 / odd), or 2^32 - 1 for odd of 1; the estimate is at most one low
	function automatic logic [31:0] recip(input logic [2:0] odd);
		logic [31:0] r;
		begin
			case (odd)
				3'd3:    r = 32'h5555_5555;
				3'd5:    r = 32'h3333_3333;
				3'd7:    r = 32'h2492_4924;
				default: r = 32'hFFFF_FFFF;
			endcase
			return r;
		end
	endfunction

endpackage

>>> hdl/sdcd_req_if.sv
// Request channel: valid/ready handshake carrying the requested card clock rate.
interface sdcd_req_if;
	logic                          valid;
	logic                          ready;
	logic [sdcd_pkg::REQ_W-1:0]    req_hz;

	modport source (output valid, output req_hz, input ready);
	modport sink   (input valid, input req_hz, output ready);
endinterface

>>> hdl/sdcd_rsp_if.sv
// Result channel: valid/ready handshake carrying the clock register word and its fields.
interface sdcd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sdcd_pkg::WORD_W-1:0]   clk_word;
	logic                          clk_source;
	logic [sdcd_pkg::PDIV_W-1:0]   pre_div_exp;
	logic [sdcd_pkg::MDIV_W-1:0]   div_m_minus_one;
	logic [sdcd_pkg::HZ_W-1:0]     parent_hz;

	modport source (output valid, output clk_word, output clk_source, output pre_div_exp,
		output div_m_minus_one, output parent_hz, input ready);
	modport sink   (input valid, input clk_word, input clk_source, input pre_div_exp,
		input div_m_minus_one, input parent_hz, output ready);
endinterface

>>> hdl/sdmmc_clock_divider_select.sv
// Top level: pipelined SD/MMC card clock divider selection.
//
// Usage:
//   req  - request channel (valid/ready), req_hz = wanted card clock in Hz.
//          A request of zero is accepted and produces no result.
//   rsp  - result channel (valid/ready): clock register word with gate bit,
//          plus source, P, M-1 and the parent clock rate.
//   cfg_we/cfg_wdata - write of the peripheral PLL control word; only
//          change it while no request is in flight.
// Throughput: one request per cycle while rsp is not stalled; eight register stages (PLL rate by
//   reciprocal multiply in stages 1-3, 8-bit restoring divide two quotient
//   bits per stage in 4-7, P/M encode into the output register in 8).
// Stalls: each stage holds while the next is full and blocked; bubbles
//   collapse, so req.ready drops only when all stages hold data and rsp
//   is stalled. Nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits and the PLL control word to 0.
module sdmmc_clock_divider_select (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	sdcd_req_if.sink                req,
	sdcd_rsp_if.source              rsp
);

	logic [31:0] cfg_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;

	logic [sdcd_pkg::REQ_W-1:0] req_s1, req_s2;
	logic                       src_s1, src_s2, src_s3, src_s4, src_s5, src_s6, src_s7;
	logic [31:0]                y_s1, y_s2;
	logic [2:0]                 odd_s1, odd_s2;
	logic [31:0]                qe_s2;
	logic [31:0]                par_s3, par_s4, par_s5, par_s6, par_s7;
	logic [31:0]                den_s3, den_s4, den_s5, den_s6;
	logic [31:0]                rem_s4, rem_s5, rem_s6;
	logic [7:0]                 q_s4, q_s5, q_s6, q_s7;
	logic                       sat_s4, sat_s5, sat_s6, sat_s7;

	logic [sdcd_pkg::WORD_W-1:0] word_s8;
	logic                        src_s8;
	logic [1:0]                  p_s8;
	logic [3:0]                  mm1_s8;
	logic [31:0]                 par_s8;

	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] den,
		input logic [2:0] sh);
		logic [39:0] dsh;
		begin
			dsh = {8'd0, den} << sh;
			if ({8'd0, rem} >= dsh) begin
				return {1'b1, rem - dsh[31:0]};
			end else begin
				return {1'b0, rem};
			end
		end
	endfunction

	// stage 1: PLL numerator and divisor split
	logic [8:0]           n_p1;
	logic [4:0]           k_c;
	sdcd_pkg::kdiv_t      kd_c;
	logic [31:0]          xnum_c;

	assign n_p1   = {1'b0, cfg_q[15:8]} + 9'd1;
	assign k_c    = {1'b0, {1'b0, cfg_q[18:16]} + 4'd1} << cfg_q[1];
	assign kd_c   = sdcd_pkg::split_k(k_c);
	assign xnum_c = sdcd_pkg::PLL_HALF_HZ * {23'd0, n_p1};

	// stage 2: reciprocal multiply
	logic [63:0] prod_c;
	assign prod_c = {32'd0, y_s1} * {32'd0, sdcd_pkg::recip(odd_s1)};

	// stage 3: quotient correction and parent select
	logic [35:0] qo_c;
	logic [31:0] r_c, pll_c;
	assign qo_c  = {4'd0, qe_s2} * {33'd0, odd_s2};
	assign r_c   = y_s2 - qo_c[31:0];
	assign pll_c = qe_s2 + {31'd0, (r_c >= {29'd0, odd_s2})};

	// stages 4-7: quotient bits 7..0
	logic [32:0] st7_c, st6_c, st5_c, st4_c, st3_c, st2_c, st1_c, st0_c;
	assign st7_c = div_step(par_s3, den_s3, 3'd7);
	assign st6_c = div_step(st7_c[31:0], den_s3, 3'd6);
	assign st5_c = div_step(rem_s4, den_s4, 3'd5);
	assign st4_c = div_step(st5_c[31:0], den_s4, 3'd4);
	assign st3_c = div_step(rem_s5, den_s5, 3'd3);
	assign st2_c = div_step(st3_c[31:0], den_s5, 3'd2);
	assign st1_c = div_step(rem_s6, den_s6, 3'd1);
	assign st0_c = div_step(st1_c[31:0], den_s6, 3'd0);

	// stage 8: P and M encode
	logic [7:0] qf_c, div_c;
	logic [1:0] p_c;
	logic [8:0] m9_c;
	logic [4:0] m_c;
	assign qf_c  = sat_s7 ? 8'hFF : q_s7;
	assign div_c = (qf_c == 8'd0) ? 8'd1 : qf_c;
	always_comb begin
		if (div_c <= 8'd16) begin
			p_c = 2'd0;
		end else if (div_c <= 8'd32) begin
			p_c = 2'd1;
		end else if (div_c <= 8'd64) begin
			p_c = 2'd2;
		end else begin
			p_c = 2'd3;
		end
	end
	assign m9_c = ({1'b0, div_c} + ((9'd1 << p_c) - 9'd1)) >> p_c;
	assign m_c  = (m9_c > 9'd16) ? 5'd16 : m9_c[4:0];

	// stall chain
	assign adv_s8 = !vld_s8 || rsp.ready;
	assign adv_s7 = !vld_s7 || adv_s8;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (adv_s1) vld_s1 <= req.valid && (req.req_hz != '0);
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			req_s1 <= req.req_hz;
			src_s1 <= req.req_hz > sdcd_pkg::OSC_LIMIT_HZ;
			y_s1   <= xnum_c >> kd_c.sh;
			odd_s1 <= kd_c.odd;
		end
		if (adv_s2) begin
			req_s2 <= req_s1;
			src_s2 <= src_s1;
			y_s2   <= y_s1;
			odd_s2 <= odd_s1;
			qe_s2  <= prod_c[63:32];
		end
		if (adv_s3) begin
			src_s3 <= src_s2;
			par_s3 <= src_s2 ? pll_c : sdcd_pkg::OSC_HZ;
			den_s3 <= {req_s2, 1'b0};
		end
		if (adv_s4) begin
			src_s4 <= src_s3;
			par_s4 <= par_s3;
			den_s4 <= den_s3;
			sat_s4 <= {8'd0, par_s3[31:8]} >= den_s3;
			rem_s4 <= st6_c[31:0];
			q_s4   <= {st7_c[32], st6_c[32], 6'd0};
		end
		if (adv_s5) begin
			src_s5 <= src_s4;
			par_s5 <= par_s4;
			den_s5 <= den_s4;
			sat_s5 <= sat_s4;
			rem_s5 <= st4_c[31:0];
			q_s5   <= {q_s4[7:6], st5_c[32], st4_c[32], 4'd0};
		end
		if (adv_s6) begin
			src_s6 <= src_s5;
			par_s6 <= par_s5;
			den_s6 <= den_s5;
			sat_s6 <= sat_s5;
			rem_s6 <= st2_c[31:0];
			q_s6   <= {q_s5[7:4], st3_c[32], st2_c[32], 2'd0};
		end
		if (adv_s7) begin
			src_s7 <= src_s6;
			par_s7 <= par_s6;
			sat_s7 <= sat_s6;
			q_s7   <= {q_s6[7:2], st1_c[32], st0_c[32]};
		end
		if (adv_s8) begin
			src_s8  <= src_s7;
			p_s8    <= p_c;
			mm1_s8  <= 4'(m_c - 5'd1);
			par_s8  <= par_s7;
			word_s8 <= {1'b1, 6'd0, src_s7, 14'd0, p_c, 4'd0, 4'(m_c - 5'd1)};
		end
	end

	assign rsp.valid           = vld_s8;
	assign rsp.clk_word        = word_s8;
	assign rsp.clk_source      = src_s8;
	assign rsp.pre_div_exp     = p_s8;
	assign rsp.div_m_minus_one = mm1_s8;
	assign rsp.parent_hz       = par_s8;

`ifndef SYNTHESIS
	a_word_fields: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> word_s8[31] && (word_s8[24] == src_s8) && (word_s8[9:8] == p_s8)
			&& (word_s8[3:0] == mm1_s8))
		else $error("clock word fields disagree with result fields");

	a_osc_parent: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && !src_s8) |-> (par_s8 == sdcd_pkg::OSC_HZ))
		else $error("oscillator source with wrong parent rate");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7
			&& vld_s8 && !rsp.ready))
		else $error("request stalled with a bubble in the pipeline");

	a_no_zero_req: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (req_s1 != '0))
		else $error("zero request entered the pipeline");

	a_pll_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && adv_s3) |-> (r_c < {29'd0, odd_s2, 1'b0}))
		else $error("reciprocal estimate off by more than one");
`endif

endmodule
